// ===== hw/rtl/blum_blum_shub_generator_top_assert.svh =====
// assertion macros for the blum blum shub generator
// plain text macros, no dependencies
`ifndef BLUM_BLUM_SHUB_GENERATOR_TOP_ASSERT_SVH
`define BLUM_BLUM_SHUB_GENERATOR_TOP_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define BBS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define BBS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/bbs_pkg.sv =====
// shared types and constants of the blum blum shub generator
// no dependencies
package bbs_pkg;

  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 64;

  // register index, taken from paddr bit 3 (registers sit at 8*i)
  localparam logic [0:0] REG_MODULUS = 1'b0;
  localparam logic [0:0] REG_SEED    = 1'b1;

  localparam logic [63:0] MODULUS_RESET = 64'd512504565321;
  localparam logic [63:0] SEED_RESET    = 64'd496880664266;

  // controller to datapath
  typedef struct packed {
    logic load;     // take a new value at request accept
    logic restart;  // load from seed instead of keeping current value
    logic clear;    // modulus below two, next value is zero
    logic init;     // clear accumulator, preset bit counter
    logic step;     // one shift-add-reduce step
    logic reduce;   // step reduces the value instead of squaring it
  } bbs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic n_small;   // modulus is zero or one
    logic x_ge_n;    // current value not below modulus
    logic cnt_zero;  // last bit of the scan
  } bbs_status_t;

endpackage

// ===== hw/rtl/bbs_if.sv =====
// request and response channel interfaces of the blum blum shub generator
// no dependencies
interface bbs_req_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface bbs_rsp_if #(
  parameter int unsigned VALUE_WIDTH = 40
);
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] random_value;

  modport source (output valid, output random_value, input ready);
  modport sink (input valid, input random_value, output ready);
endinterface

// ===== hw/rtl/bbs_datapath.sv =====
// value register and shared shift-add-reduce unit
// depends on bbs_pkg
module bbs_datapath #(
  parameter int unsigned VALUE_WIDTH = 40
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  bbs_pkg::bbs_cmd_t       cmd_i,
  input  logic [VALUE_WIDTH-1:0]  modulus_i,
  input  logic [VALUE_WIDTH-1:0]  seed_i,
  output bbs_pkg::bbs_status_t    status_o,
  output logic [VALUE_WIDTH-1:0]  emit_value_o
);

  localparam int unsigned CNT_W = $clog2(VALUE_WIDTH);
  localparam int unsigned T_W   = VALUE_WIDTH + 2;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(VALUE_WIDTH - 1);

  logic [VALUE_WIDTH-1:0] cur_q, cur_d;
  logic [VALUE_WIDTH-1:0] acc_q, acc_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;

  logic                   scan_bit;
  logic [T_W-1:0]         addend;
  logic [T_W-1:0]         sum;
  logic [T_W-1:0]         n1;
  logic [T_W-1:0]         n2;
  logic [VALUE_WIDTH-1:0] step_res;

  assign emit_value_o = cmd_i.restart ? seed_i : cur_q;

  // sum = 2*acc + addend stays below 3n, so at most two subtractions of n
  assign scan_bit = cur_q[cnt_q];
  assign n1       = {2'b00, modulus_i};
  assign n2       = {1'b0, modulus_i, 1'b0};

  always_comb begin
    if (cmd_i.reduce) begin
      addend = {{(T_W-1){1'b0}}, scan_bit};
    end else if (scan_bit) begin
      addend = {2'b00, cur_q};
    end else begin
      addend = '0;
    end
    sum = {1'b0, acc_q, 1'b0} + addend;
    if (sum >= n2) begin
      step_res = VALUE_WIDTH'(sum - n2);
    end else if (sum >= n1) begin
      step_res = VALUE_WIDTH'(sum - n1);
    end else begin
      step_res = sum[VALUE_WIDTH-1:0];
    end
  end

  assign status_o.n_small  = (modulus_i[VALUE_WIDTH-1:1] == '0);
  assign status_o.x_ge_n   = (cur_q >= modulus_i);
  assign status_o.cnt_zero = (cnt_q == '0);

  always_comb begin
    cur_d = cur_q;
    acc_d = acc_q;
    cnt_d = cnt_q;
    if (cmd_i.load) begin
      cur_d = emit_value_o;
    end
    if (cmd_i.clear) begin
      cur_d = '0;
    end
    if (cmd_i.init) begin
      acc_d = '0;
      cnt_d = CNT_MAX;
    end
    if (cmd_i.step) begin
      if (cnt_q == '0) begin
        cur_d = step_res;
        acc_d = '0;
        cnt_d = CNT_MAX;
      end else begin
        acc_d = step_res;
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q <= bbs_pkg::SEED_RESET[VALUE_WIDTH-1:0];
      cnt_q <= CNT_MAX;
    end else begin
      cur_q <= cur_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

endmodule

// ===== hw/rtl/bbs_ctrl.sv =====
// sequencer for load, optional reduction and bit-serial modular squaring
// depends on bbs_pkg
module bbs_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_valid_i,
  input  logic                 req_restart_i,
  input  logic                 out_free_i,
  input  bbs_pkg::bbs_status_t status_i,
  output logic                 req_ready_o,
  output bbs_pkg::bbs_cmd_t    cmd_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_CHECK  = 2'd1;
  localparam logic [1:0] ST_REDUCE = 2'd2;
  localparam logic [1:0] ST_SQUARE = 2'd3;

  logic [1:0] state_q, state_d;

  assign req_ready_o = (state_q == ST_IDLE) && out_free_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (req_valid_i && req_ready_o) begin
          cmd_o.load    = 1'b1;
          cmd_o.restart = req_restart_i;
          state_d       = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status_i.n_small) begin
          cmd_o.clear = 1'b1;
          state_d     = ST_IDLE;
        end else begin
          cmd_o.init = 1'b1;
          state_d    = status_i.x_ge_n ? ST_REDUCE : ST_SQUARE;
        end
      end
      ST_REDUCE: begin
        cmd_o.step   = 1'b1;
        cmd_o.reduce = 1'b1;
        if (status_i.cnt_zero) begin
          state_d = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        cmd_o.step = 1'b1;
        if (status_i.cnt_zero) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hw/rtl/blum_blum_shub_generator_top.sv =====
// blum blum shub generator top: apb registers, response register, ctrl and datapath
// response: the beat is registered, valid in the cycle after its request beat is accepted
// requests: a new request is taken only when idle and the response register is free, never
//   during the one-bit-a-cycle modular squaring loop or its reduction pass (value not below modulus)
// reset: async active low, registers and current value take their reset values at once
// depends on bbs_pkg, bbs_if, bbs_ctrl, bbs_datapath and the assertion header
module blum_blum_shub_generator_top #(
  parameter int unsigned VALUE_WIDTH = 40
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  bbs_req_if.sink                           req_i,
  bbs_rsp_if.source                         rsp_o,
  input  logic                              psel_i,
  input  logic                              penable_i,
  input  logic                              pwrite_i,
  input  logic [bbs_pkg::APB_ADDR_W-1:0]    paddr_i,
  input  logic [bbs_pkg::APB_DATA_W-1:0]    pwdata_i,
  output logic [bbs_pkg::APB_DATA_W-1:0]    prdata_o,
  output logic                              pready_o
);

`include "blum_blum_shub_generator_top_assert.svh"

  // configuration registers, masked to the value width
  logic [VALUE_WIDTH-1:0] modulus_q;
  logic [VALUE_WIDTH-1:0] seed_q;
  logic                   cfg_wr;
  logic [0:0]             cfg_idx;

  // response register parts the request side from a stalled sink
  logic                   rsp_valid_q;
  logic [VALUE_WIDTH-1:0] rsp_data_q;
  logic                   out_free;
  logic                   req_fire;

  bbs_pkg::bbs_cmd_t      cmd;
  bbs_pkg::bbs_status_t   status;
  logic [VALUE_WIDTH-1:0] emit_value;

  // apb: no wait states, register index from address bit 3
  assign pready_o = 1'b1;
  assign cfg_idx  = paddr_i[3];
  assign cfg_wr   = psel_i && penable_i && pwrite_i;

  always_comb begin
    case (cfg_idx)
      bbs_pkg::REG_MODULUS: prdata_o = bbs_pkg::APB_DATA_W'(modulus_q);
      bbs_pkg::REG_SEED:    prdata_o = bbs_pkg::APB_DATA_W'(seed_q);
      default:              prdata_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= bbs_pkg::MODULUS_RESET[VALUE_WIDTH-1:0];
      seed_q    <= bbs_pkg::SEED_RESET[VALUE_WIDTH-1:0];
    end else if (cfg_wr) begin
      case (cfg_idx)
        bbs_pkg::REG_MODULUS: modulus_q <= pwdata_i[VALUE_WIDTH-1:0];
        bbs_pkg::REG_SEED:    seed_q    <= pwdata_i[VALUE_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // a new request may enter while the previous beat drains this cycle
  assign out_free = !rsp_valid_q || rsp_o.ready;
  assign req_fire = req_i.valid && req_i.ready;

  bbs_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (req_i.valid),
    .req_restart_i (req_i.restart),
    .out_free_i    (out_free),
    .status_i      (status),
    .req_ready_o   (req_i.ready),
    .cmd_o         (cmd)
  );

  bbs_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .modulus_i    (modulus_q),
    .seed_i       (seed_q),
    .status_o     (status),
    .emit_value_o (emit_value)
  );

  // the emitted beat is the value before squaring, captured at accept
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (req_fire) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      rsp_data_q <= emit_value;
    end
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.random_value = rsp_data_q;

  // a request never overwrites a response beat that is still stalled
  `BBS_ASSERT_NOW(a_no_overwrite, clk_i, rst_ni, req_fire, (!rsp_valid_q || rsp_o.ready), "request accepted over a stalled response")
  // every accepted request shows its response beat in the next cycle
  `BBS_ASSERT_NEXT(a_rsp_follows, clk_i, rst_ni, req_fire, rsp_valid_q, "response beat missing after request")
  // the squaring run blocks further requests right after an accept
  `BBS_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, req_fire, !req_i.ready, "ready high while squaring")

endmodule

// ===== dv/tb_blum_blum_shub_generator_top.sv =====
// testbench for blum_blum_shub_generator_top: a directed table, then random request phases
// separated by register writes, each response beat checked against a modular squaring predictor
// depends on bbs_pkg, bbs_if and the generator rtl
module tb_blum_blum_shub_generator_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned VW              = 40;
  localparam int unsigned CLK_PERIOD      = 10;
  localparam int unsigned RESET_CYCLES    = 10;
  localparam int unsigned NUM_PHASES      = 8;
  localparam int unsigned BEATS_PER_PHASE = 190;   // about 1500 random requests in all
  localparam int unsigned IDLE_PCT        = 13;
  localparam int unsigned HOLD_AFTER      = 300;   // response beats before the long hold-off
  localparam int unsigned HOLD_CYCLES     = 400;
  // the squaring loop keeps running after its beat went out
  localparam int unsigned SETTLE_CYCLES   = 2 * VW + 20;
  localparam int unsigned CYCLE_LIMIT     = 1_000_000;
  localparam logic [VW-1:0] VALUE_MASK    = '1;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // register port
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [bbs_pkg::APB_ADDR_W-1:0] paddr;
  logic [bbs_pkg::APB_DATA_W-1:0] pwdata;
  logic [bbs_pkg::APB_DATA_W-1:0] prdata;
  logic                           pready;

  bbs_req_if req_if ();
  bbs_rsp_if #(.VALUE_WIDTH(VW)) rsp_if ();

  blum_blum_shub_generator_top #(
    .VALUE_WIDTH(VW)
  ) i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_if),
    .rsp_o     (rsp_if),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready)
  );

  // predictor state: our own copy of the registers and of the held value
  logic [VW-1:0] bbs_modulus;
  logic [VW-1:0] bbs_seed;
  logic [VW-1:0] bbs_value;

  // values the block should emit, oldest first
  logic [VW-1:0] exp_values[$];

  int unsigned mismatches;
  int unsigned beats_seen;
  int unsigned cycles;
  bit          calm;          // set while neither side may idle
  logic [VW-1:0] want;

  // directed table: either a register write or a request, with the emitted value
  // typed in where it follows directly from the registers
  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e                      kind;
    logic [0:0]                     reg_idx;
    logic [bbs_pkg::APB_DATA_W-1:0] wdata;
    bit                             restart;
    bit                             typed;
    logic [VW-1:0]                  exp_val;
  } stim_row_t;

  localparam int unsigned NUM_ROWS = 26;

  stim_row_t directed_rows [NUM_ROWS] = '{
    // out of reset: the held value is the reset seed
    '{ROW_REQ, bbs_pkg::REG_MODULUS, 64'd0, 1'b0, 1'b1, 40'd496880664266},
    '{ROW_REQ, bbs_pkg::REG_MODULUS, 64'd0, 1'b0, 1'b0, 40'd0},
    '{ROW_REQ, bbs_pkg::REG_MODULUS, 64'd0, 1'b1, 1'b1, 40'd496880664266},
    '{ROW_REQ, bbs_pkg::REG_MODULUS, 64'd0, 1'b0, 1'b0, 40'd0},
    // all-ones modulus and a seed equal to it, junk above bit 39
    '{ROW_CFG, bbs_pkg::REG_MODULUS, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 40'd0},
    '{ROW_CFG, bbs_pkg::REG_SEED,    64'hABCD_00FF_FFFF_FFFF, 1'b0, 1'b0, 40'd0},
    '{ROW_REQ, bbs_pkg::REG_MODULUS, 64'd0, 1'b1, 1'b1, 40'hFF_FFFF_FFFF},
    '{ROW_REQ, bbs_pkg::REG_MODULUS, 64'd0, 1'b0, 1'b1, 40'd0},
    // modulus three with a seed far above it
    '{ROW_CFG, bbs_pkg::REG_MODULUS, 64'h5A00_0000_0000_0003, 1'b0, 1'b0, 40'd0},
    '{ROW_CFG, bbs_pkg::REG_SEED,    64'h0000_00FF_FFFF_FFFE, 1'b0, 1'b0, 40'd0},
    '{ROW_REQ, bbs_pkg::REG_MODULUS, 64'd0, 1'b1, 1'b1, 40'hFF_FFFF_FFFE},
    '{ROW_REQ, bbs_pkg::REG_MODULUS, 64'd0, 1'b0, 1'b0, 40'd0},
    '{ROW_REQ, bbs_pkg::REG_MODULUS, 64'd0, 1'b0, 1'b0, 40'd0},
    // modulus zero: next value is zero
    '{ROW_CFG, bbs_pkg::REG_MODULUS, 64'd0, 1'b0, 1'b0, 40'd0},
    '{ROW_REQ, bbs_pkg::REG_MODULUS, 64'd0, 1'b1, 1'b1, 40'hFF_FFFF_FFFE},
    '{ROW_REQ, bbs_pkg::REG_MODULUS, 64'd0, 1'b0, 1'b1, 40'd0},
    // modulus one with junk on top, zero seed
    '{ROW_CFG, bbs_pkg::REG_MODULUS, 64'hFFFF_FF00_0000_0001, 1'b0, 1'b0, 40'd0},
    '{ROW_CFG, bbs_pkg::REG_SEED,    64'd0, 1'b0, 1'b0, 40'd0},
    '{ROW_REQ, bbs_pkg::REG_MODULUS, 64'd0, 1'b1, 1'b1, 40'd0},
    '{ROW_REQ, bbs_pkg::REG_MODULUS, 64'd0, 1'b0, 1'b1, 40'd0},
    // back to the reset modulus, small seed squares without wrapping at first
    '{ROW_CFG, bbs_pkg::REG_MODULUS, 64'h8000_0000_0000_0000 | bbs_pkg::MODULUS_RESET,
      1'b0, 1'b0, 40'd0},
    '{ROW_CFG, bbs_pkg::REG_SEED,    64'd5, 1'b0, 1'b0, 40'd0},
    '{ROW_REQ, bbs_pkg::REG_MODULUS, 64'd0, 1'b1, 1'b1, 40'd5},
    '{ROW_REQ, bbs_pkg::REG_MODULUS, 64'd0, 1'b0, 1'b1, 40'd25},
    '{ROW_REQ, bbs_pkg::REG_MODULUS, 64'd0, 1'b0, 1'b1, 40'd625},
    '{ROW_REQ, bbs_pkg::REG_MODULUS, 64'd0, 1'b0, 1'b0, 40'd0}
  };

  // exact (x * x) mod n on a double-width product; n below two yields zero
  function automatic logic [VW-1:0] square_residue(input logic [VW-1:0] x,
                                                   input logic [VW-1:0] n);
    logic [2*VW-1:0] r;
    if (n < 2) return '0;
    r = (2*VW)'(x % n);
    r = r * r;
    return VW'(r % n);
  endfunction

  // value emitted for one request, then advance the held value
  function automatic logic [VW-1:0] emit_and_square(input bit restart);
    logic [VW-1:0] emitted;
    if (restart) bbs_value = bbs_seed;
    emitted   = bbs_value;
    bbs_value = square_residue(bbs_value, bbs_modulus);
    return emitted;
  endfunction

  task automatic report_mismatch(input string what, input logic [VW-1:0] got,
                                 input logic [VW-1:0] exp_v);
    $display("[%0t] %s: got 0x%010h, expected 0x%010h", $realtime, what, got, exp_v);
    mismatches++;
  endtask

  // apb write: setup cycle, then access cycle until pready, then the bus returns to idle
  task automatic write_reg(input logic [0:0] idx,
                           input logic [bbs_pkg::APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    // bits above the value width are dropped by the block
    case (idx)
      bbs_pkg::REG_MODULUS: bbs_modulus = data[VW-1:0];
      bbs_pkg::REG_SEED:    bbs_seed    = data[VW-1:0];
      default: ;
    endcase
  endtask

  // one request beat, with random idle cycles ahead of it
  task automatic send_beat(input bit restart, input bit typed, input logic [VW-1:0] typed_val);
    logic [VW-1:0] emitted;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      req_if.valid   <= 1'b0;
      req_if.restart <= 1'($urandom);   // noise while not valid
      @(posedge clk_i);
    end
    req_if.valid   <= 1'b1;
    req_if.restart <= restart;
    do @(posedge clk_i); while (!req_if.ready);
    emitted = emit_and_square(restart);
    exp_values.push_back(typed ? typed_val : emitted);
  endtask

  // wait for every expected beat, then let the squaring loop finish
  task automatic drain();
    req_if.valid <= 1'b0;
    while (exp_values.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [VW-1:0] rand_value();
    return {8'($urandom), 32'($urandom)};
  endfunction

  // modulus class by phase, so every kind of setting is visited
  function automatic logic [VW-1:0] pick_modulus(input int unsigned phase);
    case (phase)
      0:       return rand_value() | {1'b1, {(VW-1){1'b0}}};
      1:       return VW'($urandom_range(3, 255));
      2:       return rand_value();
      3:       return VW'($urandom_range(0, 1));
      4:       return VALUE_MASK;
      5:       return bbs_pkg::MODULUS_RESET[VW-1:0];
      6:       return VW'($urandom_range(3, 32'h000F_FFFF));
      default: return rand_value();
    endcase
  endfunction

  function automatic logic [VW-1:0] pick_seed();
    case ($urandom_range(0, 3))
      0:       return rand_value();
      1:       return VALUE_MASK - VW'($urandom_range(0, 15));   // mostly at or above n
      2:       return (bbs_modulus != 0) ? rand_value() % bbs_modulus : '0;
      default: return VW'($urandom_range(0, 2));
    endcase
  endfunction

  // response checker: compare every accepted beat with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      beats_seen++;
      if (exp_values.size() == 0) begin
        report_mismatch("response beat with nothing expected", rsp_if.random_value, '0);
      end else begin
        want = exp_values.pop_front();
        if (rsp_if.random_value !== want)
          report_mismatch("random_value", rsp_if.random_value, want);
      end
    end
  end

  // receiver: random back-pressure, plus one long hold-off that fills the block
  initial begin
    int unsigned hold_left;
    bit          hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!hold_done && beats_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else if (!calm && $urandom_range(99) < IDLE_PCT) begin
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats outstanding", cycles, exp_values.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // stimulus
  initial begin
    bit busy;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    req_if.valid   <= 1'b0;
    req_if.restart <= 1'b0;
    mismatches = 0;
    beats_seen = 0;
    cycles     = 0;
    calm       = 1'b0;
    busy       = 1'b0;

    // predictor starts from the reset values
    bbs_modulus = bbs_pkg::MODULUS_RESET[VW-1:0];
    bbs_seed    = bbs_pkg::SEED_RESET[VW-1:0];
    bbs_value   = bbs_pkg::SEED_RESET[VW-1:0];

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table; registers are only written once the block is idle
    for (int i = 0; i < NUM_ROWS; i++) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        if (busy) drain();
        busy = 1'b0;
        write_reg(directed_rows[i].reg_idx, directed_rows[i].wdata);
      end else begin
        send_beat(directed_rows[i].restart, directed_rows[i].typed, directed_rows[i].exp_val);
        busy = 1'b1;
      end
    end

    // random phases: new modulus and seed, then long sequences with sparse restarts
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      write_reg(bbs_pkg::REG_MODULUS, {24'($urandom), pick_modulus(ph)});
      write_reg(bbs_pkg::REG_SEED, {24'($urandom), pick_seed()});
      for (int k = 0; k < BEATS_PER_PHASE; k++) begin
        // one long stretch where neither side idles
        calm = (ph == 2) && (k >= 40) && (k < 200);
        send_beat((k == 0) || ($urandom_range(7) == 0), 1'b0, '0);
      end
      calm = 1'b0;
    end

    drain();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
